FILE: rtl/address_symbol_floor_lookup_assert.svh
// ----------------------------------------------------------------------------
// address symbol floor lookup assertion macros
// shared property forms for the lookup block checks
// ----------------------------------------------------------------------------
`ifndef ADDRESS_SYMBOL_FLOOR_LOOKUP_ASSERT_SVH
`define ADDRESS_SYMBOL_FLOOR_LOOKUP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ASFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asfl check failed");

// next-cycle implication, checked outside reset
`define ASFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asfl check failed");

`endif

FILE: rtl/asfl_pkg.sv
// ----------------------------------------------------------------------------
// asfl_pkg
// shared widths and state codes for the address symbol floor lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asfl_pkg;

  localparam int COUNT_W = 11;  // entry count register
  localparam int INDEX_W = 10;  // entry and symbol index fields
  localparam int ADDR_W  = 64;  // start and query addresses

  localparam logic ACTION_WRITE  = 1'b0;
  localparam logic ACTION_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

FILE: rtl/asfl_table.sv
// ----------------------------------------------------------------------------
// asfl_table
// start address store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asfl_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [asfl_pkg::ADDR_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [asfl_pkg::ADDR_W-1:0] rdata
);

  logic [asfl_pkg::ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/address_symbol_floor_lookup.sv
// ----------------------------------------------------------------------------
// address_symbol_floor_lookup
// floor search over an ascending table of symbol start addresses
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_ready) carries action, entry_index, address.
//   a write request stores address in slot entry_index and gives no result;
//   slots at or above TABLE_DEPTH are dropped. a lookup request searches the
//   first entry_count slots for the greatest start address not above the
//   query and returns found, symbol_index and offset on the output channel
//   (out_valid / out_ready).
//   entry_count is loaded through entry_count_we / entry_count_wdata; the
//   user must load it only while the block is idle, which the block itself
//   does not enforce. a lookup caps the count it uses at TABLE_DEPTH.
//   a lookup makes at most floor(log2(n)) + 1 probes for n entries in use
//   and none with an empty table. the probe loop does one table read per
//   cycle through the registered read port.
//   one lookup is in flight at a time; the next request is taken once the
//   result sits in the output register, even if the receiver stalls it.
//   reset clears the control state and entry_count; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "address_symbol_floor_lookup_assert.svh"

module address_symbol_floor_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          entry_count_we,
  input  logic [asfl_pkg::COUNT_W-1:0]  entry_count_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [asfl_pkg::INDEX_W-1:0]  entry_index,
  input  logic [asfl_pkg::ADDR_W-1:0]   address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [asfl_pkg::INDEX_W-1:0]  symbol_index,
  output logic [asfl_pkg::ADDR_W-1:0]   offset
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = asfl_pkg::COUNT_W;
  // largest usable count, limited by both the table and the register width
  localparam logic [CW-1:0] COUNT_CAP =
    (TABLE_DEPTH >= (1 << CW)) ? {CW{1'b1}} : CW'(TABLE_DEPTH);

  asfl_pkg::state_t state, state_next;

  logic [CW-1:0]                 entry_count;
  logic [CW-1:0]                 lo, lo_next;
  logic [CW-1:0]                 hi, hi_next;
  logic [CW-1:0]                 mid, mid_next;
  logic [asfl_pkg::ADDR_W-1:0]   query;
  logic [asfl_pkg::ADDR_W-1:0]   best, best_next;

  logic                          in_fire;
  logic                          is_write;
  logic                          is_lookup;
  logic [CW-1:0]                 hi_init;
  logic                          slot_ok;
  logic                          le;
  logic                          rd_en;
  logic                          out_load;
  logic [asfl_pkg::ADDR_W-1:0]   rdata;

  // table store
  asfl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (is_write && slot_ok),
    .waddr (AW'(entry_index)),
    .wdata (address),
    .re    (rd_en),
    .raddr (AW'(mid_next)),
    .rdata (rdata)
  );

  assign in_ready  = (state == asfl_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_write  = in_fire && (action == asfl_pkg::ACTION_WRITE);
  assign is_lookup = in_fire && (action == asfl_pkg::ACTION_LOOKUP);
  assign slot_ok   = (32'(entry_index) < 32'(TABLE_DEPTH));
  assign hi_init   = (entry_count > COUNT_CAP) ? COUNT_CAP : entry_count;

  // probe result: entry at mid is at or below the query
  assign le = (rdata <= query);

  // drain the finished result into the output register when it is free
  assign out_load = (state == asfl_pkg::ST_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    best_next  = best;
    mid_next   = mid;
    rd_en      = 1'b0;
    case (state)
      asfl_pkg::ST_IDLE: begin
        if (is_lookup) begin
          lo_next  = '0;
          hi_next  = hi_init;
          mid_next = hi_init >> 1;
          if (hi_init != '0) begin
            rd_en      = 1'b1;
            state_next = asfl_pkg::ST_SEARCH;
          end else begin
            // empty table goes straight to the not-found answer
            state_next = asfl_pkg::ST_FINISH;
          end
        end
      end
      asfl_pkg::ST_SEARCH: begin
        if (le) begin
          lo_next   = mid + CW'(1);
          best_next = rdata;  // entry lo-1 is always the last mid taken
        end else begin
          hi_next = mid;
        end
        mid_next = lo_next + ((hi_next - lo_next) >> 1);
        if (lo_next < hi_next) begin
          rd_en = 1'b1;
        end else begin
          state_next = asfl_pkg::ST_FINISH;
        end
      end
      asfl_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = asfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = asfl_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= asfl_pkg::ST_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (entry_count_we) begin
        entry_count <= entry_count_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    best <= best_next;
    if (is_lookup) begin
      query <= address;
    end
  end

  // result register, final subtract happens here
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (lo != '0) begin
        found        <= 1'b1;
        symbol_index <= asfl_pkg::INDEX_W'(lo - CW'(1));
        offset       <= query - best;
      end else begin
        found        <= 1'b0;
        symbol_index <= '0;
        offset       <= query;
      end
    end
  end

  // checks
  `ASFL_ASSERT_IMPLY(a_search_range, clk, rst,
    state == asfl_pkg::ST_SEARCH, lo < hi && mid >= lo && mid < hi)
  `ASFL_ASSERT_IMPLY(a_miss_index_zero, clk, rst,
    out_valid && !found, symbol_index == '0)
  `ASFL_ASSERT_IMPLY(a_result_from_finish, clk, rst,
    $rose(out_valid), $past(state == asfl_pkg::ST_FINISH))
  `ASFL_ASSERT_NEXT(a_write_stays_idle, clk, rst,
    is_write, state == asfl_pkg::ST_IDLE)

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the address symbol floor lookup: a local mirror of
// the start address table predicts every lookup, a checker process compares
// each result field by field, and the request side runs directed cases,
// a full table load, random lookups and backpressure under varied idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 16;    // margin for the worst lookup and a trailing write to finish
  localparam int QUIET_LIMIT   = 2000;  // well above the longest legal hold, HOLD_CYCLES
  localparam int ITEM_TARGET   = 1150;
  localparam int HOLD_CYCLES   = 150;
  localparam int MAX_PRINTS    = 40;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic                         found;
    logic [asfl_pkg::INDEX_W-1:0] symbol_index;
    logic [asfl_pkg::ADDR_W-1:0]  offset;
  } floor_result_t;

  // dut ports, inputs driven to known values from time zero
  logic                         clk;
  logic                         rst = 1'b1;
  logic                         entry_count_we = 1'b0;
  logic [asfl_pkg::COUNT_W-1:0] entry_count_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         action = asfl_pkg::ACTION_WRITE;
  logic [asfl_pkg::INDEX_W-1:0] entry_index = '0;
  logic [asfl_pkg::ADDR_W-1:0]  address = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         found;
  logic [asfl_pkg::INDEX_W-1:0] symbol_index;
  logic [asfl_pkg::ADDR_W-1:0]  offset;

  // mirror of the block state
  logic [asfl_pkg::ADDR_W-1:0]  start_addr_tbl [0:TABLE_DEPTH-1];
  logic [asfl_pkg::COUNT_W-1:0] entry_count_cfg = '0;

  // lookup answers still owed by the block, oldest first
  floor_result_t pending_answers[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int items_sent     = 0;
  int random_lookups = 0;
  int mismatch_count = 0;

  address_symbol_floor_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) DUT (
    .clk               (clk),
    .rst               (rst),
    .entry_count_we    (entry_count_we),
    .entry_count_wdata (entry_count_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .action            (action),
    .entry_index       (entry_index),
    .address           (address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .found             (found),
    .symbol_index      (symbol_index),
    .offset            (offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // upper-bound binary search: lo ends on the first entry above the query,
  // so the covering entry is lo - 1; counts past the table are capped
  function automatic floor_result_t floor_lookup(logic [asfl_pkg::ADDR_W-1:0] query);
    int lo;
    int hi;
    int mid;
    floor_result_t answer;
    hi = (entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg);
    lo = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (start_addr_tbl[mid] <= query) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) begin
      // empty table or query below the first entry: raw query passes through
      answer.found        = 1'b0;
      answer.symbol_index = '0;
      answer.offset       = query;
    end else begin
      answer.found        = 1'b1;
      answer.symbol_index = asfl_pkg::INDEX_W'(lo - 1);
      answer.offset       = query - start_addr_tbl[lo - 1];
    end
    return answer;
  endfunction

  // queries cluster on entry boundaries, where off-by-one bugs live
  function automatic logic [asfl_pkg::ADDR_W-1:0] pick_query();
    int n;
    int k;
    logic [asfl_pkg::ADDR_W-1:0] q;
    n = (entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg);
    q = {$urandom, $urandom};
    if (n > 0) begin
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 7))
        0, 1: q = start_addr_tbl[k];
        2, 3: q = start_addr_tbl[k] + $urandom_range(0, 255);
        4: q = start_addr_tbl[k] - 1;
        5: q = '0;
        6: q = '1;
        default: ;
      endcase
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;  recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 63; recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;  recv_stall_pct = 63;
      end
      default: begin
        send_idle_pct = 32; recv_stall_pct = 32;
      end
    endcase
  endtask

  // offers one request and returns at the edge that takes it; valid is left
  // high so back-to-back requests keep it asserted
  task automatic send_request(logic act, logic [asfl_pkg::INDEX_W-1:0] slot,
                              logic [asfl_pkg::ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= slot;
    address     <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (act == asfl_pkg::ACTION_WRITE) start_addr_tbl[slot] = addr;
    else pending_answers.push_back(floor_lookup(addr));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // block is idle once every answer is back and any trailing write has landed
  task automatic wait_idle();
    stop_sending();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(logic [asfl_pkg::COUNT_W-1:0] value);
    wait_idle();
    entry_count_we    <= 1'b1;
    entry_count_wdata <= value;
    @(posedge clk);
    entry_count_we  <= 1'b0;
    entry_count_cfg = value;
  endtask

  task automatic lookup(logic [asfl_pkg::ADDR_W-1:0] query);
    send_request(asfl_pkg::ACTION_LOOKUP, '0, query);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string field, logic [asfl_pkg::ADDR_W-1:0] got,
                                 logic [asfl_pkg::ADDR_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: %s mismatch, got %h want %h", $realtime, field, got, want);
  endtask

  // checks at each edge, then picks ready for the next one
  initial begin
    floor_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result", offset, '0);
        end else begin
          want = pending_answers.pop_front();
          if (found !== want.found)
            report_mismatch("found", asfl_pkg::ADDR_W'(found),
                            asfl_pkg::ADDR_W'(want.found));
          if (symbol_index !== want.symbol_index)
            report_mismatch("symbol_index", asfl_pkg::ADDR_W'(symbol_index),
                            asfl_pkg::ADDR_W'(want.symbol_index));
          if (offset !== want.offset)
            report_mismatch("offset", offset, want.offset);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // count zero: every query comes back not found with the raw address
  task automatic test_empty_table();
    set_entry_count('0);
    lookup('0);
    lookup('1);
  endtask

  // four entries, last one near the top of the address space
  task automatic test_small_table();
    send_request(asfl_pkg::ACTION_WRITE, 10'd0, 64'h100);
    send_request(asfl_pkg::ACTION_WRITE, 10'd1, 64'h200);
    send_request(asfl_pkg::ACTION_WRITE, 10'd2, 64'h300);
    send_request(asfl_pkg::ACTION_WRITE, 10'd3, 64'hFFFF_FFFF_FFFF_FFF0);
    set_entry_count(11'd4);
    lookup(64'hFF);                    // just below the first entry
    lookup(64'h100);                   // exact first entry
    lookup(64'h250);                   // between entries
    lookup('1);                        // top address, last entry
    lookup('0);
    set_entry_count(11'd1);
    lookup(64'h300);                   // later entries are out of range
  endtask

  // descending contents: the search just follows its fixed probe path
  task automatic test_unsorted_table();
    for (int i = 0; i < 8; i++)
      send_request(asfl_pkg::ACTION_WRITE, asfl_pkg::INDEX_W'(i),
                   64'h8000 - 64'(i) * 64'h1000);
    set_entry_count(11'd8);
    lookup(64'h5000);
    lookup(64'h8000);
    lookup('0);
    lookup('1);
  endtask

  // loads all slots in ascending order with random gaps and some duplicates,
  // then hits the count extremes including the capped ones
  task automatic test_full_table();
    logic [asfl_pkg::ADDR_W-1:0] next_addr;
    logic [asfl_pkg::ADDR_W-1:0] gap;
    next_addr = 64'd1 + $urandom_range(0, 255);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i % 256 == 0) set_idling(idle_mode_t'(2'(i / 256)));
      if (i == TABLE_DEPTH - 1) next_addr = '1;
      send_request(asfl_pkg::ACTION_WRITE, asfl_pkg::INDEX_W'(i), next_addr);
      // each gap stays below 2**54, so the walk cannot wrap over 1024 slots
      if ($urandom_range(0, 15) == 0) gap = '0;
      else gap = {$urandom, $urandom} >> $urandom_range(10, 60);
      next_addr += gap;
    end
    set_idling(IDLE_NONE);
    set_entry_count(11'd1024);
    lookup('0);
    lookup(start_addr_tbl[0]);
    lookup('1);
    lookup(start_addr_tbl[512] - 1);
    set_entry_count(11'd2047);
    lookup('1);
    lookup(pick_query());
    set_entry_count(11'd1025);
    lookup(pick_query());
    set_entry_count(11'd1023);
    lookup('1);
  endtask

  // segments of lookups, each under one idling mode; some segments reload a
  // short prefix or change the count, a few stray writes add noise
  task automatic test_random_traffic();
    int seg;
    int n;
    logic [asfl_pkg::ADDR_W-1:0] next_addr;
    seg = 0;
    while (items_sent < ITEM_TARGET || random_lookups < 80) begin
      set_idling(idle_mode_t'(2'(seg)));
      case ($urandom_range(0, 2))
        0: set_entry_count(asfl_pkg::COUNT_W'($urandom_range(0, 2047)));
        1: begin
          n = $urandom_range(1, 24);
          next_addr = {$urandom, $urandom} >> $urandom_range(0, 63);
          for (int i = 0; i < n; i++) begin
            send_request(asfl_pkg::ACTION_WRITE, asfl_pkg::INDEX_W'(i), next_addr);
            next_addr += {$urandom, $urandom} >> $urandom_range(20, 63);
          end
          set_entry_count(asfl_pkg::COUNT_W'(n));
        end
        default: ;
      endcase
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 7) == 0) begin
          send_request(asfl_pkg::ACTION_WRITE,
                       asfl_pkg::INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                       {$urandom, $urandom});
        end else begin
          lookup(pick_query());
          random_lookups++;
        end
      end
      seg++;
    end
  endtask

  // receiver holds off while lookups keep coming, so the block backs up and
  // drops in_ready; the drain afterwards waits for every answer
  task automatic test_output_backpressure();
    set_idling(IDLE_NONE);
    set_entry_count(11'd1024);
    hold_cycles = HOLD_CYCLES;
    repeat (8) lookup(pick_query());
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_idling(IDLE_NONE);
    test_empty_table();
    test_small_table();
    test_unsorted_table();
    test_full_table();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
